### sv/prrs_pkg.sv
// prrs_pkg: constants, codes and controller/datapath types of the
// priority round-robin scheduler; no dependencies
package prrs_pkg;

  localparam int MAX_TASKS       = 8;
  localparam int PRIORITY_LEVELS = 4;
  localparam int TICK_BITS       = 16;

  localparam int KIND_W   = 3;
  localparam int PRIO_W   = 2;
  localparam int TIDX_W   = 3;
  localparam int BTICK_W  = 16;
  localparam int NEXT_W   = 4;
  localparam int ASSIGN_W = 3;

  localparam int ID_W   = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int TASK_W = $clog2(MAX_TASKS + 1);
  localparam int CNT_W  = $clog2(MAX_TASKS + 1);
  localparam int LVL_W  = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1;

  localparam logic [TASK_W-1:0] IDLE_ID = TASK_W'(MAX_TASKS);

  localparam logic [KIND_W-1:0] KIND_ADD   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_START = 3'd1;
  localparam logic [KIND_W-1:0] KIND_TICK  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_YIELD = 3'd3;
  localparam logic [KIND_W-1:0] KIND_BLOCK = 3'd4;

  localparam logic [1:0] TS_READY   = 2'd0;
  localparam logic [1:0] TS_RUNNING = 2'd1;
  localparam logic [1:0] TS_BLOCKED = 2'd2;

  typedef struct packed {
    logic accept;
    logic dec;
    logic first;
    logic step;
    logic commit;
    logic load;
  } prrs_cmd_t;

  typedef struct packed {
    logic started;
    logic fin;
    logic out_free;
  } prrs_sts_t;

endpackage

### sv/prrs_in_if.sv
// prrs_in_if: request channel of the scheduler
// depends on prrs_pkg
interface prrs_in_if;
  import prrs_pkg::*;
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [PRIO_W-1:0]   priority_req;
  logic [TIDX_W-1:0]   task_index;
  logic [BTICK_W-1:0]  block_ticks;
  modport source (output valid, kind, priority_req, task_index, block_ticks, input ready);
  modport sink   (input valid, kind, priority_req, task_index, block_ticks, output ready);
endinterface

### sv/prrs_out_if.sv
// prrs_out_if: result channel of the scheduler
// depends on prrs_pkg
interface prrs_out_if;
  import prrs_pkg::*;
  logic                valid;
  logic                ready;
  logic [NEXT_W-1:0]   next_task;
  logic                switch_needed;
  logic [ASSIGN_W-1:0] assigned_id;
  logic                error_code;
  modport source (output valid, next_task, switch_needed, assigned_id, error_code, input ready);
  modport sink   (input valid, next_task, switch_needed, assigned_id, error_code, output ready);
endinterface

### sv/prrs_ctrl.sv
// prrs_ctrl: sequencing state machine of the scheduler
// depends on prrs_pkg
module prrs_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [prrs_pkg::KIND_W-1:0] in_kind,
  output logic                        in_ready,
  input  prrs_pkg::prrs_sts_t         sts,
  output prrs_pkg::prrs_cmd_t         cmd
);
  import prrs_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DEC    = 3'd1;
  localparam logic [2:0] ST_SCHED  = 3'd2;
  localparam logic [2:0] ST_COMMIT = 3'd3;
  localparam logic [2:0] ST_OUT    = 3'd4;

  logic [2:0] state_r, state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (in_kind == KIND_TICK) state_nxt = ST_DEC;
          else if (in_kind == KIND_YIELD) state_nxt = ST_SCHED;
          else state_nxt = ST_OUT;
        end
      end
      ST_DEC: begin
        cmd.dec = 1'b1;
        state_nxt = ST_SCHED;
      end
      ST_SCHED: begin
        if (!sts.started) begin
          cmd.first = 1'b1;
          state_nxt = ST_OUT;
        end else begin
          cmd.step = 1'b1;
          if (sts.fin) state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.load = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

endmodule

### sv/prrs_dp.sv
// prrs_dp: task tables, level scan step and result register
// depends on prrs_pkg
module prrs_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  prrs_pkg::prrs_cmd_t           cmd,
  output prrs_pkg::prrs_sts_t           sts,
  input  logic [prrs_pkg::KIND_W-1:0]   in_kind,
  input  logic [prrs_pkg::PRIO_W-1:0]   in_prio,
  input  logic [prrs_pkg::TIDX_W-1:0]   in_tidx,
  input  logic [prrs_pkg::BTICK_W-1:0]  in_bticks,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [prrs_pkg::NEXT_W-1:0]   out_next,
  output logic                          out_sw,
  output logic [prrs_pkg::ASSIGN_W-1:0] out_assigned,
  output logic                          out_err
);
  import prrs_pkg::*;

  logic [LVL_W-1:0]     prio_r  [MAX_TASKS];
  logic [1:0]           stat_r  [MAX_TASKS];
  logic [TICK_BITS-1:0] ticks_r [MAX_TASKS];
  logic [CNT_W-1:0]     lcnt_r  [PRIORITY_LEVELS];
  logic [CNT_W-1:0]     lptr_r  [PRIORITY_LEVELS];
  logic [CNT_W-1:0]     ntask_r;
  logic [TASK_W-1:0]    run_r;
  logic                 started_r;
  logic [LVL_W-1:0]     lvl_r;
  logic [CNT_W-1:0]     tot_r;
  logic [CNT_W-1:0]     here_r;
  logic                 sw_r;
  logic [TASK_W-1:0]    next_r;
  logic [ID_W-1:0]      assigned_r;
  logic                 err_r;
  logic                 out_valid_r;
  logic [NEXT_W-1:0]    out_next_r;
  logic                 out_sw_r;
  logic [ASSIGN_W-1:0]  out_assigned_r;
  logic                 out_err_r;

  logic [CNT_W-1:0]  cnt, ptr, kk, ptr_w, tot_n, here_n;
  logic [ID_W-1:0]   cand;
  logic [CNT_W-1:0]  seen;
  logic              found;
  logic [1:0]        es;
  logic              wake, last_lvl, fin, fin_sw, adv, blk;
  logic [TASK_W-1:0] fin_id;
  logic [LVL_W-1:0]  add_lvl;
  logic [ID_W-1:0]   run_idx, next_idx;

  assign add_lvl  = (int'(in_prio) >= PRIORITY_LEVELS) ? LVL_W'(PRIORITY_LEVELS - 1)
                                                      : LVL_W'(in_prio);
  assign run_idx  = run_r[ID_W-1:0];
  assign next_idx = next_r[ID_W-1:0];

  // candidate selection for one scan step
  always_comb begin
    cnt  = lcnt_r[lvl_r];
    ptr  = lptr_r[lvl_r];
    kk   = (ptr >= cnt) ? ptr - cnt : ptr;
    cand = '0;
    seen = '0;
    found = 1'b0;
    for (int i = 0; i < MAX_TASKS; i++) begin
      if (CNT_W'(i) < ntask_r && prio_r[i] == lvl_r) begin
        if (!found && seen == kk) begin
          cand  = ID_W'(i);
          found = 1'b1;
        end
        seen = seen + 1'b1;
      end
    end
    wake     = (stat_r[cand] == TS_BLOCKED) && (ticks_r[cand] == '0);
    es       = wake ? TS_READY : stat_r[cand];
    last_lvl = (lvl_r == LVL_W'(PRIORITY_LEVELS - 1));
    tot_n    = tot_r + 1'b1;
    here_n   = here_r + 1'b1;
    fin      = 1'b0;
    fin_sw   = 1'b1;
    fin_id   = IDLE_ID;
    adv      = 1'b0;
    blk      = 1'b0;
    ptr_w    = kk + 1'b1;
    if (cnt == '0) begin
      ptr_w = '0;
      adv   = 1'b1;
      fin   = last_lvl;
    end else if (es == TS_READY) begin
      fin    = 1'b1;
      fin_id = TASK_W'(cand);
    end else if (es == TS_RUNNING) begin
      fin    = 1'b1;
      fin_sw = 1'b0;
      fin_id = TASK_W'(cand);
    end else begin
      blk = 1'b1;
      if (tot_n == ntask_r) begin
        fin = 1'b1;
      end else if (here_n >= cnt) begin
        ptr_w = '0;
        adv   = 1'b1;
        fin   = last_lvl;
      end
    end
  end

  assign sts.started  = started_r;
  assign sts.fin      = fin;
  assign sts.out_free = !out_valid_r || out_ready;

  // task tables
  always_ff @(posedge clk) begin
    if (cmd.accept && in_kind == KIND_ADD && ntask_r < CNT_W'(MAX_TASKS)) begin
      prio_r[ntask_r[ID_W-1:0]] <= add_lvl;
      stat_r[ntask_r[ID_W-1:0]] <= TS_READY;
    end
    if (cmd.accept && in_kind == KIND_START && run_r < IDLE_ID
        && stat_r[run_idx] == TS_RUNNING) begin
      stat_r[run_idx] <= TS_READY;
    end
    if (cmd.accept && in_kind == KIND_BLOCK && int'(in_tidx) < int'(ntask_r)) begin
      stat_r[ID_W'(in_tidx)] <= TS_BLOCKED;
    end
    if (cmd.step && cnt != '0 && wake) begin
      stat_r[cand] <= TS_READY;
    end
    if (cmd.commit && sw_r) begin
      if (run_r < IDLE_ID && stat_r[run_idx] == TS_RUNNING) stat_r[run_idx] <= TS_READY;
      if (next_r < IDLE_ID) stat_r[next_idx] <= TS_RUNNING;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_TASKS; i++) ticks_r[i] <= '0;
      for (int l = 0; l < PRIORITY_LEVELS; l++) begin
        lcnt_r[l] <= '0;
        lptr_r[l] <= '0;
      end
      ntask_r     <= '0;
      run_r       <= IDLE_ID;
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.accept) begin
        unique case (in_kind)
          KIND_ADD: begin
            if (ntask_r < CNT_W'(MAX_TASKS)) begin
              ticks_r[ntask_r[ID_W-1:0]] <= '0;
              lcnt_r[add_lvl] <= lcnt_r[add_lvl] + 1'b1;
              ntask_r <= ntask_r + 1'b1;
            end
          end
          KIND_START: begin
            run_r     <= IDLE_ID;
            started_r <= 1'b0;
            for (int l = 0; l < PRIORITY_LEVELS; l++) lptr_r[l] <= '0;
          end
          KIND_BLOCK: begin
            if (int'(in_tidx) < int'(ntask_r)) ticks_r[ID_W'(in_tidx)] <= TICK_BITS'(in_bticks);
          end
          default: ;
        endcase
      end
      if (cmd.dec) begin
        for (int i = 0; i < MAX_TASKS; i++) begin
          if (CNT_W'(i) < ntask_r && ticks_r[i] != '0) ticks_r[i] <= ticks_r[i] - 1'b1;
        end
      end
      if (cmd.first) begin
        for (int l = 0; l < PRIORITY_LEVELS; l++) lptr_r[l] <= '0;
        run_r     <= IDLE_ID;
        started_r <= 1'b1;
      end
      if (cmd.step) lptr_r[lvl_r] <= ptr_w;
      if (cmd.commit && sw_r) run_r <= next_r;
      if (cmd.load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // scan and result payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      lvl_r      <= '0;
      tot_r      <= '0;
      here_r     <= '0;
      sw_r       <= 1'b0;
      assigned_r <= '0;
      err_r      <= 1'b0;
      if (in_kind == KIND_ADD) begin
        if (ntask_r < CNT_W'(MAX_TASKS)) assigned_r <= ntask_r[ID_W-1:0];
        else err_r <= 1'b1;
      end
    end
    if (cmd.first) sw_r <= 1'b1;
    if (cmd.step) begin
      if (blk) tot_r <= tot_n;
      if (adv) begin
        here_r <= '0;
        if (!last_lvl) lvl_r <= lvl_r + 1'b1;
      end else if (blk) begin
        here_r <= here_n;
      end
      if (fin) begin
        sw_r   <= fin_sw;
        next_r <= fin_id;
      end
    end
    if (cmd.load) begin
      out_next_r     <= NEXT_W'(run_r);
      out_sw_r       <= sw_r;
      out_assigned_r <= ASSIGN_W'(assigned_r);
      out_err_r      <= err_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_next     = out_next_r;
  assign out_sw       = out_sw_r;
  assign out_assigned = out_assigned_r;
  assign out_err      = out_err_r;

endmodule

### sv/priority_round_robin_scheduler.sv
// Priority round-robin task scheduler, top level.
// Request channel in_ch carries kind (add, start, tick, yield, block),
// priority_req, task_index and block_ticks; result channel out_ch returns
// next_task (8 = idle), switch_needed, assigned_id and error_code, exactly
// one result transaction per request transaction.
// Add, start, block and unused kinds go from accept straight to the result
// load. A yield runs the level scan and then a commit step; a tick first
// decrements the block counters. The scan has at most MAX_TASKS +
// PRIORITY_LEVELS - 1 steps: one candidate task or one empty level per cycle.
// The first schedule after reset or start selects idle without a scan.
// One request is processed at a time; in_ch.ready is high only while the
// block waits for a request. The result register frees as out_ch takes it,
// so a stalled receiver holds back only the next result, not the next accept.
// Synchronous reset (rst_n low) empties the task table, clears block
// counters, level pointers and the result valid flag, and selects idle.
// depends on prrs_pkg, prrs_in_if, prrs_out_if, prrs_ctrl, prrs_dp
module priority_round_robin_scheduler (
  input logic        clk,
  input logic        rst_n,
  prrs_in_if.sink    in_ch,
  prrs_out_if.source out_ch
);
  import prrs_pkg::*;

  prrs_cmd_t cmd;
  prrs_sts_t sts;

  prrs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_kind  (in_ch.kind),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  prrs_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_kind      (in_ch.kind),
    .in_prio      (in_ch.priority_req),
    .in_tidx      (in_ch.task_index),
    .in_bticks    (in_ch.block_ticks),
    .out_ready    (out_ch.ready),
    .out_valid    (out_ch.valid),
    .out_next     (out_ch.next_task),
    .out_sw       (out_ch.switch_needed),
    .out_assigned (out_ch.assigned_id),
    .out_err      (out_ch.error_code)
  );

endmodule

### sv/prrs_checker.sv
// prrs_checker: port-level checks of the scheduler and their bind
// depends on prrs_pkg and priority_round_robin_scheduler
module prrs_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [prrs_pkg::NEXT_W-1:0]   next_task,
  input logic                          switch_needed,
  input logic [prrs_pkg::ASSIGN_W-1:0] assigned_id,
  input logic                          error_code
);
  import prrs_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_err_no_switch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && error_code |-> !switch_needed && assigned_id == '0)
    else $error("rejected add reports switch or id");

  a_next_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> int'(next_task) <= MAX_TASKS)
    else $error("next_task out of range");

  a_id_no_switch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && assigned_id != '0 |-> !switch_needed && !error_code)
    else $error("add result reports switch");

endmodule

bind priority_round_robin_scheduler prrs_checker u_prrs_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .next_task     (out_ch.next_task),
  .switch_needed (out_ch.switch_needed),
  .assigned_id   (out_ch.assigned_id),
  .error_code    (out_ch.error_code)
);
